// ----- rtl/core/ellmv_pkg.sv -----
`default_nettype none

package ellmv_pkg;

   // fixed field widths
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned ELEM_W     = 32;
   localparam int unsigned ACC_W      = 64;
   localparam int unsigned ROWS_W     = 11;
   localparam int unsigned ELL_W      = 9;
   localparam int unsigned SLOT_W     = 8;
   localparam int unsigned MAX_SLOTS  = 256;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ACT_LOAD_VEC = 2'd0,
      ACT_PRELOAD  = 2'd1,
      ACT_ENTRY    = 2'd2,
      ACT_READ     = 2'd3
   } action_type;

   typedef enum logic {
      REG_ROWS_IN_USE = 1'b0,
      REG_ELL_WIDTH   = 1'b1
   } csr_reg_type;

   // classified work handed from front to back
   typedef struct packed {
      action_type               action;
      logic [IDX_W-1:0]         vec_raw;
      logic [IDX_W-1:0]         vec_quo;
      logic [ROWS_W-1:0]        acc_raw;
      logic [IDX_W-1:0]         acc_quo;
      logic signed [ELEM_W-1:0] element;
      logic signed [ACC_W-1:0]  preload;
      logic                     sweep_done;
   } work_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] read_value;
      logic                    is_read;
      logic                    sweep_done;
      logic                    saturated;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/ellmv_req_if.sv -----
`default_nettype none

interface ellmv_req_if;
   import ellmv_pkg::*;

   logic                     valid;
   logic                     ready;
   action_type               action;
   logic [IDX_W-1:0]         index;
   logic signed [ELEM_W-1:0] element_value;
   logic [IDX_W-1:0]         column_index;
   logic signed [ACC_W-1:0]  accumulator_value;

   modport source (
      output valid, action, index, element_value, column_index, accumulator_value,
      input  ready
   );

   modport sink (
      input  valid, action, index, element_value, column_index, accumulator_value,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/ellmv_rsp_if.sv -----
`default_nettype none

interface ellmv_rsp_if;
   import ellmv_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] read_value;
   logic                    is_read;
   logic                    sweep_done;
   logic                    saturated;

   modport source (
      output valid, read_value, is_read, sweep_done, saturated,
      input  ready
   );

   modport sink (
      input  valid, read_value, is_read, sweep_done, saturated,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/ellmv_ram.sv -----
`default_nettype none

module ellmv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ----- rtl/core/ellmv_queue.sv -----
`default_nettype none

module ellmv_queue #(
   parameter type         item_type = logic,
   parameter int unsigned DEPTH     = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire item_type                   in_item,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output item_type                        out_item,
   output logic [$clog2(DEPTH+1)-1:0]      count
);
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

`default_nettype wire

// ----- rtl/core/ellmv_front.sv -----
`default_nettype none

module ellmv_front #(
   parameter int unsigned VECTOR_DEPTH = 1024,
   parameter int unsigned ROW_DEPTH    = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ellmv_req_if.sink                         req_chan,
   input  wire logic [ellmv_pkg::ROWS_W-1:0] rows_in_use,
   input  wire logic [ellmv_pkg::ELL_W-1:0]  ell_width,
   output logic                              work_valid,
   input  wire logic                         work_ready,
   output ellmv_pkg::work_type               work
);
   import ellmv_pkg::*;

   // reciprocal constants, exact quotient for any 10-bit address
   localparam int unsigned VEC_SHIFT = IDX_W + $clog2(VECTOR_DEPTH);
   localparam longint unsigned VEC_MULT =
      ((longint'(1) << VEC_SHIFT) + longint'(VECTOR_DEPTH) - 1) / longint'(VECTOR_DEPTH);
   localparam int unsigned ROW_SHIFT = IDX_W + $clog2(ROW_DEPTH);
   localparam longint unsigned ROW_MULT =
      ((longint'(1) << ROW_SHIFT) + longint'(ROW_DEPTH) - 1) / longint'(ROW_DEPTH);

   function automatic logic [IDX_W-1:0] quo_vec(input logic [IDX_W-1:0] n);
      logic [63:0] p;
      p = 64'(n) * 64'(VEC_MULT);
      return IDX_W'(p >> VEC_SHIFT);
   endfunction

   function automatic logic [IDX_W-1:0] quo_row(input logic [IDX_W-1:0] n);
      logic [63:0] p;
      p = 64'(n) * 64'(ROW_MULT);
      return IDX_W'(p >> ROW_SHIFT);
   endfunction

   logic [ROWS_W-1:0] row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ROWS_W-1:0] eff_rows;
   logic [ELL_W-1:0]  eff_width;
   logic              accept;
   logic              is_entry;
   logic              row_last;
   logic              slot_last;
   logic [IDX_W-1:0]  vec_raw;

   assign req_chan.ready = work_ready;
   assign accept         = req_chan.valid && work_ready;
   assign is_entry       = (req_chan.action == ACT_ENTRY);

   always_comb begin
      if (rows_in_use == '0) begin
         eff_rows = ROWS_W'(1);
      end else if (32'(rows_in_use) > ROW_DEPTH) begin
         eff_rows = ROWS_W'(ROW_DEPTH);
      end else begin
         eff_rows = rows_in_use;
      end
      if (ell_width == '0) begin
         eff_width = ELL_W'(1);
      end else if (32'(ell_width) > MAX_SLOTS) begin
         eff_width = ELL_W'(MAX_SLOTS);
      end else begin
         eff_width = ell_width;
      end
   end

   assign row_last  = (32'(row_ff) + 32'd1 >= 32'(eff_rows));
   assign slot_last = (32'(slot_ff) + 32'd1 >= 32'(eff_width));

   always_comb begin
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept && is_entry) begin
         if (row_last) begin
            row_in  = '0;
            slot_in = slot_last ? '0 : slot_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   assign vec_raw = is_entry ? req_chan.column_index : req_chan.index;

   always_comb begin
      work.action     = req_chan.action;
      work.vec_raw    = vec_raw;
      work.vec_quo    = quo_vec(vec_raw);
      work.acc_raw    = is_entry ? row_ff : ROWS_W'(req_chan.index);
      work.acc_quo    = is_entry ? '0 : quo_row(req_chan.index);
      work.element    = req_chan.element_value;
      work.preload    = req_chan.accumulator_value;
      work.sweep_done = is_entry && row_last && slot_last;
   end

   assign work_valid = req_chan.valid;

   a_sweep_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && is_entry && row_last && slot_last) |=> (row_ff == '0 && slot_ff == '0))
      else $error("counters did not wrap at end of sweep");

   a_counters_idle: assert property (@(posedge clock) disable iff (reset)
      !(accept && is_entry) |=> ($stable(row_ff) && $stable(slot_ff)))
      else $error("counters moved without a matrix entry");
endmodule

`default_nettype wire

// ----- rtl/core/ellmv_back.sv -----
`default_nettype none

module ellmv_back #(
   parameter int unsigned VECTOR_DEPTH = 1024,
   parameter int unsigned ROW_DEPTH    = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                work_valid,
   output logic                     work_pop,
   input  wire ellmv_pkg::work_type work,
   ellmv_rsp_if.source              rsp_chan
);
   import ellmv_pkg::*;

   localparam int unsigned VA        = $clog2(VECTOR_DEPTH);
   localparam int unsigned RA        = $clog2(ROW_DEPTH);
   localparam int unsigned RES_DEPTH = 4;
   localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH+1);
   localparam int unsigned OCC_W     = RES_CNT_W + 1;

   // issue stage
   logic                  issue;
   logic [OCC_W-1:0]      occupancy;
   logic [RES_CNT_W-1:0]  res_count;
   logic                  res_in_ready;
   logic [VA-1:0]         vec_addr;
   logic [RA-1:0]         acc_addr;
   logic                  vec_wr_en;
   logic [ELEM_W-1:0]     vec_rd;
   logic [ACC_W-1:0]      acc_rd;

   // multiply stage
   logic                     b_valid_ff;
   action_type               b_action_ff;
   logic [RA-1:0]            b_addr_ff;
   logic signed [ELEM_W-1:0] b_element_ff;
   logic signed [ACC_W-1:0]  b_preload_ff;
   logic                     b_done_ff;
   logic signed [ACC_W-1:0]  b_prod;
   logic signed [ACC_W-1:0]  b_acc;

   // accumulate stage
   logic                    c_valid_ff;
   action_type              c_action_ff;
   logic [RA-1:0]           c_addr_ff;
   logic signed [ACC_W-1:0] c_prod_ff;
   logic signed [ACC_W-1:0] c_acc_ff;
   logic signed [ACC_W-1:0] c_preload_ff;
   logic                    c_done_ff;
   logic signed [ACC_W-1:0] c_acc;
   logic signed [ACC_W-1:0] c_sum;
   logic                    c_ovf;
   logic signed [ACC_W-1:0] c_sat_sum;
   logic                    acc_wr_en;
   logic signed [ACC_W-1:0] acc_wr_data;
   result_type              c_result;

   // last accumulator write, covers the ram's read-to-write gap
   logic                    wb_valid_ff;
   logic [RA-1:0]           wb_addr_ff;
   logic signed [ACC_W-1:0] wb_data_ff;

   result_type res_item;
   logic       res_valid;

   assign occupancy = OCC_W'(res_count) + OCC_W'(b_valid_ff) + OCC_W'(c_valid_ff);
   assign issue     = work_valid && (occupancy < OCC_W'(RES_DEPTH));
   assign work_pop  = issue;

   assign vec_addr  = VA'(32'(work.vec_raw) - 32'(work.vec_quo) * 32'(VECTOR_DEPTH));
   assign acc_addr  = RA'(32'(work.acc_raw) - 32'(work.acc_quo) * 32'(ROW_DEPTH));
   assign vec_wr_en = issue && (work.action == ACT_LOAD_VEC);

   ellmv_ram #(.WIDTH(ELEM_W), .DEPTH(VECTOR_DEPTH)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (vec_addr),
      .wr_data (work.element),
      .rd_addr (vec_addr),
      .rd_data (vec_rd)
   );

   ellmv_ram #(.WIDTH(ACC_W), .DEPTH(ROW_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (c_addr_ff),
      .wr_data (acc_wr_data),
      .rd_addr (acc_addr),
      .rd_data (acc_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         b_valid_ff  <= issue;
         c_valid_ff  <= b_valid_ff;
         wb_valid_ff <= acc_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      b_action_ff  <= work.action;
      b_addr_ff    <= acc_addr;
      b_element_ff <= work.element;
      b_preload_ff <= work.preload;
      b_done_ff    <= work.sweep_done;

      c_action_ff  <= b_action_ff;
      c_addr_ff    <= b_addr_ff;
      c_prod_ff    <= b_prod;
      c_acc_ff     <= b_acc;
      c_preload_ff <= b_preload_ff;
      c_done_ff    <= b_done_ff;

      wb_addr_ff   <= c_addr_ff;
      wb_data_ff   <= acc_wr_data;
   end

   assign b_prod = b_element_ff * $signed(vec_rd);
   assign b_acc  = (wb_valid_ff && wb_addr_ff == b_addr_ff) ? wb_data_ff : $signed(acc_rd);

   assign c_acc = (wb_valid_ff && wb_addr_ff == c_addr_ff) ? wb_data_ff : c_acc_ff;
   assign c_sum = c_acc + c_prod_ff;
   assign c_ovf = (c_acc[ACC_W-1] == c_prod_ff[ACC_W-1]) && (c_sum[ACC_W-1] != c_acc[ACC_W-1]);

   always_comb begin
      if (c_ovf) begin
         c_sat_sum = c_acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end else begin
         c_sat_sum = c_sum;
      end
   end

   assign acc_wr_en   = c_valid_ff && (c_action_ff == ACT_PRELOAD || c_action_ff == ACT_ENTRY);
   assign acc_wr_data = (c_action_ff == ACT_PRELOAD) ? c_preload_ff : c_sat_sum;

   always_comb begin
      c_result.read_value = (c_action_ff == ACT_READ) ? c_acc : '0;
      c_result.is_read    = (c_action_ff == ACT_READ);
      c_result.sweep_done = c_done_ff;
      c_result.saturated  = (c_action_ff == ACT_ENTRY) && c_ovf;
   end

   ellmv_queue #(.item_type(result_type), .DEPTH(RES_DEPTH)) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_ready  (res_in_ready),
      .in_item   (c_result),
      .out_valid (res_valid),
      .out_ready (rsp_chan.ready),
      .out_item  (res_item),
      .count     (res_count)
   );

   assign rsp_chan.valid      = res_valid;
   assign rsp_chan.read_value = res_item.read_value;
   assign rsp_chan.is_read    = res_item.is_read;
   assign rsp_chan.sweep_done = res_item.sweep_done;
   assign rsp_chan.saturated  = res_item.saturated;

   a_res_room: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> res_in_ready)
      else $error("result reached a full result queue");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(RES_DEPTH))
      else $error("items in flight exceed result space");

   a_flags_entry_only: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_action_ff != ACT_ENTRY) |-> (!c_result.saturated && !c_result.sweep_done))
      else $error("entry flags set on a non-entry beat");
endmodule

`default_nettype wire

// ----- rtl/core/ellpack_sparse_matvec.sv -----
`default_nettype none

// channel   dir  handshake              payload
// req_chan  in   valid/ready            action, index, element_value, column_index,
//                                       accumulator_value
// rsp_chan  out  valid/ready            read_value, is_read, sweep_done, saturated
// csr       in   psel/penable/pready    paddr, pwdata, prdata (rows_in_use @0, ell_width @4)
//
// one beat per cycle sustained while the response side keeps up; every request beat gives exactly one response beat
// a request passes into the work queue, then issue with ram reads, multiply, then
// accumulate with ram write into the result queue
// back-to-back entries on one row are forwarded from the last accumulator write
// reset is synchronous; it clears the row and slot counters, the queues and the stage valid
// flags, sets both config registers to one, while both stores stay undefined until written
// a stalled response side fills the four-entry result queue, then the work queue,
// then drops req_chan.ready; issue is held back by the free result slots
module ellpack_sparse_matvec #(
   parameter int unsigned VECTOR_DEPTH = 1024,
   parameter int unsigned ROW_DEPTH    = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ellmv_req_if.sink                             req_chan,
   ellmv_rsp_if.source                           rsp_chan,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ellmv_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ellmv_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ellmv_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);
   import ellmv_pkg::*;

   localparam int unsigned WORK_DEPTH = 4;

   // configuration registers
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [ELL_W-1:0]  ell_ff, ell_in;
   logic              csr_write;
   csr_reg_type       csr_sel;

   // front to back
   logic     front_valid;
   logic     front_ready;
   work_type front_work;
   logic     work_valid;
   logic     work_pop;
   work_type work_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = csr_reg_type'(paddr[2]);

   always_comb begin
      rows_in = rows_ff;
      ell_in  = ell_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_ROWS_IN_USE: rows_in = pwdata[ROWS_W-1:0];
            REG_ELL_WIDTH:   ell_in  = pwdata[ELL_W-1:0];
            default:         rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_W'(1);
         ell_ff  <= ELL_W'(1);
      end else begin
         rows_ff <= rows_in;
         ell_ff  <= ell_in;
      end
   end

   // register readback
   always_comb begin
      unique case (csr_sel)
         REG_ROWS_IN_USE: prdata = CSR_DATA_W'(rows_ff);
         REG_ELL_WIDTH:   prdata = CSR_DATA_W'(ell_ff);
         default:         prdata = '0;
      endcase
   end

   // front: classify, step row and slot counters, compute address quotients
   ellmv_front #(.VECTOR_DEPTH(VECTOR_DEPTH), .ROW_DEPTH(ROW_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rows_in_use (rows_ff),
      .ell_width   (ell_ff),
      .work_valid  (front_valid),
      .work_ready  (front_ready),
      .work        (front_work)
   );

   // decouples intake from the store pipeline
   ellmv_queue #(.item_type(work_type), .DEPTH(WORK_DEPTH)) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_work),
      .out_valid (work_valid),
      .out_ready (work_pop),
      .out_item  (work_head),
      .count     ()
   );

   // back: stores, multiply, saturating accumulate, result queue
   ellmv_back #(.VECTOR_DEPTH(VECTOR_DEPTH), .ROW_DEPTH(ROW_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work_head),
      .rsp_chan   (rsp_chan)
   );
endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ellmv_pkg::*;

   localparam int unsigned VEC_SLOTS   = 1024;
   localparam int unsigned ROW_SLOTS   = 1024;
   localparam int unsigned DRAIN_WAIT  = 10;      // extra settle time after the last response
   localparam int unsigned HOLD_CYCLES = 90;      // long response stall, fills both queues
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned SHOW_LIMIT  = 40;      // cap on printed error lines

   // one request beat as the sender sees it
   typedef struct {
      action_type               action;
      logic [IDX_W-1:0]         index;
      logic signed [ELEM_W-1:0] element;
      logic [IDX_W-1:0]         column;
      logic signed [ACC_W-1:0]  preload;
   } matvec_request;

   // shadow copy of the stores, counters and registers; predicts one response per request
   class ell_mac_tracker;
      logic signed [ELEM_W-1:0] vec_mem [VEC_SLOTS];
      logic signed [ACC_W-1:0]  acc_mem [ROW_SLOTS];
      bit                       vec_written [VEC_SLOTS];
      bit                       acc_written [ROW_SLOTS];
      logic [IDX_W-1:0]         vec_addrs [$];
      logic [IDX_W-1:0]         acc_addrs [$];
      int unsigned              row_pos;
      int unsigned              slot_pos;
      logic [ROWS_W-1:0]        rows_reg;
      logic [ELL_W-1:0]         width_reg;
      result_type               owed_results [$];
      int unsigned              fail_count;
      int unsigned              checked;
      int unsigned              reads;
      int unsigned              sweeps;
      int unsigned              clips;

      function new();
         rows_reg  = 1;
         width_reg = 1;
      endfunction

      function void note_config(csr_reg_type which, logic [CSR_DATA_W-1:0] value);
         case (which)
            REG_ROWS_IN_USE: rows_reg  = value[ROWS_W-1:0];
            REG_ELL_WIDTH:   width_reg = value[ELL_W-1:0];
         endcase
      endfunction

      function void absorb_request(matvec_request r);
         result_type              res;
         logic signed [ACC_W-1:0] lhs, rhs, prod, acc, sum;
         int unsigned             row_lim, slot_lim;
         res      = '0;
         // out-of-range register values clamp
         row_lim  = (rows_reg == 0) ? 1 : ((rows_reg > ROW_SLOTS) ? ROW_SLOTS : rows_reg);
         slot_lim = (width_reg == 0) ? 1 : ((width_reg > MAX_SLOTS) ? MAX_SLOTS : width_reg);
         case (r.action)
            ACT_LOAD_VEC: begin
               if (!vec_written[r.index]) vec_addrs.push_back(r.index);
               vec_written[r.index] = 1'b1;
               vec_mem[r.index]     = r.element;
            end
            ACT_PRELOAD: begin
               if (!acc_written[r.index]) acc_addrs.push_back(r.index);
               acc_written[r.index] = 1'b1;
               acc_mem[r.index]     = r.preload;
            end
            ACT_ENTRY: begin
               lhs  = r.element;
               rhs  = vec_mem[r.column];
               prod = lhs * rhs;
               acc  = acc_mem[row_pos];
               sum  = acc + prod;
               if (acc[ACC_W-1] == prod[ACC_W-1] && sum[ACC_W-1] != acc[ACC_W-1]) begin
                  sum           = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
                  res.saturated = 1'b1;
               end
               acc_mem[row_pos] = sum;
               // a counter left beyond a lowered bound wraps here
               if (row_pos + 1 >= row_lim) begin
                  row_pos = 0;
                  if (slot_pos + 1 >= slot_lim) begin
                     slot_pos       = 0;
                     res.sweep_done = 1'b1;
                  end else begin
                     slot_pos++;
                  end
               end else begin
                  row_pos++;
               end
            end
            ACT_READ: begin
               res.read_value = acc_mem[r.index];
               res.is_read    = 1'b1;
            end
         endcase
         owed_results.push_back(res);
      endfunction

      task report(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
         if (fail_count < SHOW_LIMIT)
            $display("ERROR at %0t: %s got %h want %h", $realtime, what, got, want);
         fail_count++;
      endtask

      task check_response(result_type seen);
         result_type want;
         if (owed_results.size() == 0) begin
            report("response beat with nothing outstanding", seen.read_value, '0);
            return;
         end
         want = owed_results.pop_front();
         checked++;
         reads  += want.is_read;
         sweeps += want.sweep_done;
         clips  += want.saturated;
         if (seen.read_value !== want.read_value)
            report("read_value", seen.read_value, want.read_value);
         if (seen.is_read !== want.is_read)
            report("is_read", 64'(seen.is_read), 64'(want.is_read));
         if (seen.sweep_done !== want.sweep_done)
            report("sweep_done", 64'(seen.sweep_done), 64'(want.sweep_done));
         if (seen.saturated !== want.saturated)
            report("saturated", 64'(seen.saturated), 64'(want.saturated));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ellmv_req_if req_if ();
   ellmv_rsp_if rsp_if ();

   ell_mac_tracker tracker;
   result_type     seen_beat;

   // idle percentages of the two sides, changed per phase
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   // long stall handshake between the main thread and the response side
   int unsigned hold_req;
   int unsigned hold_ack;
   int unsigned stall_left;
   int unsigned cycle_count;

   ellpack_sparse_matvec i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // response side: random back-pressure, or a long hold when the main thread asks
   always @(negedge clock) begin
      if (hold_ack != hold_req) begin
         hold_ack   = hold_req;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // response monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_beat.read_value = rsp_if.read_value;
         seen_beat.is_read    = rsp_if.is_read;
         seen_beat.sweep_done = rsp_if.sweep_done;
         seen_beat.saturated  = rsp_if.saturated;
         tracker.check_response(seen_beat);
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout with %0d response beats outstanding", tracker.owed_results.size());
      $display("Mismatches found");
      $finish;
   end

   // all driver tasks start and end just after a falling edge

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(input matvec_request r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.action            <= r.action;
      req_if.index             <= r.index;
      req_if.element_value     <= r.element;
      req_if.column_index      <= r.column;
      req_if.accumulator_value <= r.preload;
      do @(posedge clock); while (!req_if.ready);
      tracker.absorb_request(r);
      @(negedge clock);
   endtask

   // setup cycle, then access cycle; the register takes the value at the access edge
   task automatic csr_write(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      psel         <= 1'b1;
      penable      <= 1'b0;
      pwrite       <= 1'b1;
      paddr        <= {which, 2'b00};
      pwdata       <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.note_config(which, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // stop offering beats until every response is in, then let the pipeline settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (tracker.owed_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic matvec_request beat(action_type act, logic [IDX_W-1:0] idx,
                                          logic signed [ELEM_W-1:0] elem,
                                          logic [IDX_W-1:0] col,
                                          logic signed [ACC_W-1:0] init);
      matvec_request r;
      r.action  = act;
      r.index   = idx;
      r.element = elem;
      r.column  = col;
      r.preload = init;
      return r;
   endfunction

   // random beat that never touches a store entry before it was written
   function automatic matvec_request pick_request();
      matvec_request           r;
      logic signed [ACC_W-1:0] wide;
      int unsigned             roll;
      r.index  = IDX_W'($urandom);
      r.column = IDX_W'($urandom);
      // element mix: padding zeros, full range, and moderate magnitudes
      case ($urandom_range(0, 9))
         0:             r.element = '0;
         1, 2, 3, 4:    r.element = $urandom;
         default:       r.element = $signed($urandom) >>> $urandom_range(2, 12);
      endcase
      // preload mix: full range, small, and close to either limit so sums clip
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 2))
         0:       r.preload = wide;
         1:       r.preload = wide >>> 20;
         default: r.preload = wide[ACC_W-1] ? ACC_MIN + wide[11:0] : ACC_MAX - wide[11:0];
      endcase
      roll = $urandom_range(0, 99);
      if (!tracker.acc_written[tracker.row_pos]) begin
         // the row the next entry lands on has no accumulator yet
         r.action = ACT_PRELOAD;
         r.index  = IDX_W'(tracker.row_pos);
      end else if (roll < 58) begin
         r.action = ACT_ENTRY;
         if (!tracker.vec_written[r.column])
            r.column = tracker.vec_addrs[$urandom_range(0, tracker.vec_addrs.size() - 1)];
      end else if (roll < 72) begin
         r.action = ACT_LOAD_VEC;
      end else if (roll < 84) begin
         r.action = ACT_PRELOAD;
      end else begin
         r.action = ACT_READ;
         if (!tracker.acc_written[r.index])
            r.index = tracker.acc_addrs[$urandom_range(0, tracker.acc_addrs.size() - 1)];
      end
      return r;
   endfunction

   // one register setting with its own idle pattern, an optional stall and an optional mid-run drain
   task automatic run_phase(input int unsigned rows, input int unsigned width,
                            input int unsigned beats, input int unsigned send_pct,
                            input int unsigned recv_pct, input bit hold, input bit pause);
      wait_drained();
      csr_write(REG_ROWS_IN_USE, rows);
      csr_write(REG_ELL_WIDTH, width);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (hold) begin
         // response side holds off while beats keep coming
         @(posedge clock);
         hold_req++;
         @(negedge clock);
      end
      for (int k = 0; k < beats; k++) begin
         if (pause && k == beats / 2) wait_drained();
         send_beat(pick_request());
      end
   endtask

   initial begin
      tracker                  = new();
      reset                    = 1'b1;
      req_if.valid             = 1'b0;
      req_if.action            = ACT_LOAD_VEC;
      req_if.index             = '0;
      req_if.element_value     = '0;
      req_if.column_index      = '0;
      req_if.accumulator_value = '0;
      rsp_if.ready             = 1'b0;
      psel                     = 1'b0;
      penable                  = 1'b0;
      pwrite                   = 1'b0;
      paddr                    = '0;
      pwdata                   = '0;
      send_idle_pct            = 12;
      recv_idle_pct            = 77;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats under the reset register values: one row, one slot, so every
      // entry ends a sweep and always lands on row zero
      send_beat(beat(ACT_LOAD_VEC, 10'd0,   32'sh7FFF_FFFF, 10'd0, '0));
      send_beat(beat(ACT_LOAD_VEC, 10'h3FF, 32'sh8000_0000, 10'd0, '0));
      send_beat(beat(ACT_LOAD_VEC, 10'd512, 32'sh0100_0000, 10'd0, '0));
      send_beat(beat(ACT_LOAD_VEC, 10'd1,   32'sd1,         10'd0, '0));
      // largest positive product on a nearly full accumulator clips high
      send_beat(beat(ACT_PRELOAD, 10'd0, '0, 10'd0, 64'sh7FFF_FFFF_0000_0000));
      send_beat(beat(ACT_ENTRY,   10'd0, 32'sh7FFF_FFFF, 10'd0, '0));
      send_beat(beat(ACT_READ,    10'd0, '0, 10'd0, '0));
      // negative product on a nearly empty accumulator clips low
      send_beat(beat(ACT_PRELOAD, 10'd0, '0, 10'd0, ACC_MIN + 64'sd5));
      send_beat(beat(ACT_ENTRY,   10'd0, 32'sh7FFF_FFFF, 10'h3FF, '0));
      send_beat(beat(ACT_READ,    10'd0, '0, 10'd0, '0));
      // min times min, then a padding entry that adds nothing
      send_beat(beat(ACT_ENTRY,   10'd0, 32'sh8000_0000, 10'h3FF, '0));
      send_beat(beat(ACT_ENTRY,   10'd0, '0, 10'd512, '0));
      send_beat(beat(ACT_READ,    10'd0, '0, 10'd0, '0));
      send_beat(beat(ACT_PRELOAD, 10'h3FF, '0, 10'd0, 64'sh8000_0000_0000_0001));
      send_beat(beat(ACT_READ,    10'h3FF, '0, 10'd0, '0));
      // smallest product on the largest accumulator still clips
      send_beat(beat(ACT_PRELOAD, 10'd0, '0, 10'd0, ACC_MAX));
      send_beat(beat(ACT_ENTRY,   10'd0, 32'sd1, 10'd1, '0));
      send_beat(beat(ACT_READ,    10'd0, '0, 10'd0, '0));
      send_beat(beat(ACT_LOAD_VEC, 10'h3FF, 32'shFFFF_FFFF, 10'd0, '0));
      send_beat(beat(ACT_PRELOAD, 10'd0, '0, 10'd0, '0));
      send_beat(beat(ACT_ENTRY,   10'd0, 32'sh8000_0000, 10'h3FF, '0));
      send_beat(beat(ACT_ENTRY,   10'd0, 32'sh8000_0000, 10'd0, '0));
      send_beat(beat(ACT_READ,    10'd0, '0, 10'd0, '0));

      // sender light, receiver heavy
      run_phase(4,    3,   130, 12, 77, 1'b0, 1'b0);
      run_phase(1024, 1,   110, 12, 77, 1'b1, 1'b0);
      // zero counts act as one; the row counter is left far beyond the new bound
      run_phase(0,    0,   100, 12, 77, 1'b0, 1'b0);
      // sender heavy, receiver light; oversized counts clamp
      run_phase(2047, 2,   110, 77, 12, 1'b0, 1'b0);
      run_phase(3,    256, 130, 77, 12, 1'b0, 1'b1);
      run_phase(1,    511, 100, 77, 12, 1'b0, 1'b0);
      // no idling on either side; slot counter left beyond the new bound
      run_phase(5,    2,   130, 0,  0,  1'b1, 1'b0);
      run_phase(2,    4,   120, 0,  0,  1'b0, 1'b1);
      run_phase(7,    2,   120, 0,  0,  1'b0, 1'b0);

      wait_drained();
      $display("checked %0d response beats: %0d reads, %0d sweeps ended, %0d clipped sums",
               tracker.checked, tracker.reads, tracker.sweeps, tracker.clips);
      $display("row counts 0 to 2047 and slot counts 0 to 511, long stall and mid-run drain");
      if (tracker.fail_count == 0 && tracker.owed_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
